>>> sv/lcmwc_pkg.sv
// Package for the LRU write-back cache counter block.
// Request/response types, register indexes and reset defaults.
// No dependencies.
`default_nettype none

package lcmwc_pkg;

    localparam int ADDR_W      = 31;
    localparam int CNT_W       = 48;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int SIB_W       = 4;
    localparam int WAYS_CFG_W  = 3;
    localparam int SET_MASK_W  = 15;
    localparam int DIRTY_W     = 4;
    localparam int POP_W       = 3;

    localparam int MAX_SETS_DEF  = 2048;
    localparam int MAX_WAYS_DEF  = 4;
    localparam int ADDR_BITS_DEF = 31;

    localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 1'd1;

    localparam logic [SIB_W-1:0]      SIB_RESET  = 4'd9;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 3'd1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [ADDR_W-1:0] dword_addr;
        logic              is_store;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic             dirty_evicted;
        logic [POP_W-1:0] evicted_dirty_words;
        logic [CNT_W-1:0] fill_total;
        logic [CNT_W-1:0] writeback_line_total;
        logic [CNT_W-1:0] writeback_word_total;
    } t_rsp;

endpackage

`default_nettype wire

>>> sv/lru_cache_miss_writeback_counter.sv
// Top level: set-associative true-LRU write-back cache with fill/writeback counters.
// Depends on lcmwc_pkg and lcmwc_ram (one row per set: tags, valid, dirty, recency).
//
// Usage:
//   Request channel: a request (dword_addr, is_store) is taken at a rising edge with
//   start high and busy low. busy is high while a request is in work and during
//   the clearing pass after reset.
//   Response channel: o_valid pulses for one cycle with o_rsp; the receiver cannot
//   stall, so each response must be taken in that cycle.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 set_index_bits,
//   1 ways_in_use) at the edge; only while busy is low and no response pends.
//   Sequence: the accepting edge moves the block from idle to S_QUO (reciprocal
//   multiply for the set index), then S_REM (multiply-subtract for the modulo,
//   whose result addresses the RAM's registered read port) and S_UPD (update and
//   write-back of the set row); o_valid rises as it returns to idle, and no new
//   request is taken before then.
//   Reset: synchronous, active low. Counters and config return to defaults, then a
//   clearing pass writes every set row (MAX_SETS rows, 2048 by default) with
//   busy held high.
`default_nettype none

module lru_cache_miss_writeback_counter #(
    parameter int MAX_SETS  = lcmwc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS  = lcmwc_pkg::MAX_WAYS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    input  wire lcmwc_pkg::t_req                 i_req,
    output logic                                 busy,
    output logic                                 o_valid,
    output lcmwc_pkg::t_rsp                      o_rsp,
    input  wire                                  i_cfg_we,
    input  wire [lcmwc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [lcmwc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ADDR_BITS = lcmwc_pkg::ADDR_W;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W   = ADDR_BITS - 2;
    localparam int DW      = lcmwc_pkg::DIRTY_W;
    localparam int ENT_W   = TAG_W + DW + 1;
    localparam int ORD_LSB = MAX_WAYS * ENT_W;
    localparam int ROW_W   = ORD_LSB + MAX_WAYS * WAY_W;
    localparam int MW      = lcmwc_pkg::SET_MASK_W;
    localparam int CW      = lcmwc_pkg::CNT_W;
    localparam int PW      = lcmwc_pkg::POP_W;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(MAX_SETS));

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_QUO  = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [PW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return (s > {1'b0, lcmwc_pkg::COUNT_MAX}) ? lcmwc_pkg::COUNT_MAX : s[CW-1:0];
    endfunction

    function automatic logic [PW-1:0] pop4(input logic [DW-1:0] v);
        logic [PW-1:0] n;
        n = '0;
        for (int i = 0; i < DW; i++) begin
            n = n + PW'(v[i]);
        end
        return n;
    endfunction

    logic [2:0]                       r_state;
    logic [SET_W-1:0]                 r_clr;
    logic [TAG_W-1:0]                 r_line;
    logic [1:0]                       r_word;
    logic                             r_store;
    logic [MW-1:0]                    r_m;
    logic [15:0]                      r_q;
    logic [SET_W-1:0]                 r_set;
    logic [lcmwc_pkg::SIB_W-1:0]      r_sib;
    logic [lcmwc_pkg::WAYS_CFG_W-1:0] r_ways;
    logic [CW-1:0]                    r_fills;
    logic [CW-1:0]                    r_wbl;
    logic [CW-1:0]                    r_wbw;
    logic                             r_valid;
    lcmwc_pkg::t_rsp                  r_rsp;

    // request decode
    logic [ADDR_BITS-1:0] req_addr;
    logic [MW-1:0]        sib_mask;
    logic                 accept;

    assign req_addr = ADDR_BITS'(i_req.dword_addr);
    assign sib_mask = MW'((16'd1 << r_sib) - 16'd1);
    assign accept   = start && (r_state == S_IDLE);

    // set index modulo MAX_SETS
    logic [47:0] quo_prod;
    logic [31:0] rem_qn;
    logic [31:0] rem_raw;
    logic [31:0] rem_fix;

    assign quo_prod = 48'(r_m) * 48'(RECIP);
    assign rem_qn   = 32'(r_q) * 32'(MAX_SETS);
    assign rem_raw  = 32'(r_m) - rem_qn;
    assign rem_fix  = (rem_raw >= 32'(MAX_SETS)) ? (rem_raw - 32'(MAX_SETS)) : rem_raw;

    // set row RAM
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] clr_row;
    logic [ROW_W-1:0] upd_row;
    logic [SET_W-1:0] ram_addr;
    logic             ram_we;

    always_comb begin
        clr_row = '0;
        for (int p = 0; p < MAX_WAYS; p++) begin
            clr_row[ORD_LSB + p*WAY_W +: WAY_W] = WAY_W'(p);
        end
    end

    always_comb begin
        case (r_state)
            S_CLR:   ram_addr = r_clr;
            S_REM:   ram_addr = rem_fix[SET_W-1:0];
            default: ram_addr = r_set;
        endcase
    end

    assign ram_we    = (r_state == S_CLR) || (r_state == S_UPD);
    assign ram_wdata = (r_state == S_CLR) ? clr_row : upd_row;

    lcmwc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // lookup, replacement and recency update
    logic [3:0]       ways_eff;
    logic [TAG_W-1:0] e_tag   [MAX_WAYS];
    logic [DW-1:0]    e_dirty [MAX_WAYS];
    logic             e_valid [MAX_WAYS];
    logic [WAY_W-1:0] ord     [MAX_WAYS];
    logic             hit;
    logic [WAY_W-1:0] hit_pos;
    logic [WAY_W-1:0] pos;
    logic [WAY_W-1:0] way;
    logic             evict;
    logic [PW-1:0]    ev_words;
    logic [DW-1:0]    n_dirty;
    logic [CW-1:0]    n_fills;
    logic [CW-1:0]    n_wbl;
    logic [CW-1:0]    n_wbw;

    always_comb begin
        ways_eff = {1'b0, r_ways};
        if (ways_eff == 4'd0) begin
            ways_eff = 4'd1;
        end else if (ways_eff > 4'(MAX_WAYS)) begin
            ways_eff = 4'(MAX_WAYS);
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            e_tag[w]   = ram_rdata[w*ENT_W +: TAG_W];
            e_dirty[w] = ram_rdata[w*ENT_W + TAG_W +: DW];
            e_valid[w] = ram_rdata[w*ENT_W + TAG_W + DW];
            ord[w]     = ram_rdata[ORD_LSB + w*WAY_W +: WAY_W];
        end
        hit     = 1'b0;
        hit_pos = '0;
        for (int p = MAX_WAYS - 1; p >= 0; p--) begin
            if ((4'(p) < ways_eff) && e_valid[ord[p]] && (e_tag[ord[p]] == r_line)) begin
                hit     = 1'b1;
                hit_pos = WAY_W'(p);
            end
        end
        pos      = hit ? hit_pos : WAY_W'(ways_eff - 4'd1);
        way      = ord[pos];
        evict    = !hit && e_valid[way] && (e_dirty[way] != '0);
        ev_words = evict ? pop4(e_dirty[way]) : '0;

        n_dirty = hit ? e_dirty[way] : '0;
        if (r_store) begin
            n_dirty = n_dirty | (DW'(1) << r_word);
        end

        upd_row = ram_rdata;
        upd_row[32'(way)*ENT_W +: ENT_W] = {1'b1, n_dirty, hit ? e_tag[way] : r_line};
        upd_row[ORD_LSB +: WAY_W] = way;
        for (int p = 1; p < MAX_WAYS; p++) begin
            upd_row[ORD_LSB + p*WAY_W +: WAY_W] = (WAY_W'(p) <= pos) ? ord[p-1] : ord[p];
        end

        n_fills = hit ? r_fills : sat_add(r_fills, PW'(1));
        n_wbl   = evict ? sat_add(r_wbl, PW'(1)) : r_wbl;
        n_wbw   = evict ? sat_add(r_wbw, ev_words) : r_wbw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_sib   <= lcmwc_pkg::SIB_RESET;
            r_ways  <= lcmwc_pkg::WAYS_RESET;
            r_fills <= '0;
            r_wbl   <= '0;
            r_wbw   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == lcmwc_pkg::REG_SET_INDEX_BITS) begin
                    r_sib <= i_cfg_data[lcmwc_pkg::SIB_W-1:0];
                end else if (i_cfg_idx == lcmwc_pkg::REG_WAYS_IN_USE) begin
                    r_ways <= i_cfg_data[lcmwc_pkg::WAYS_CFG_W-1:0];
                end
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + SET_W'(1);
                    if (r_clr == SET_W'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_QUO;
                    end
                end
                S_QUO: begin
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_IDLE;
                    r_fills <= n_fills;
                    r_wbl   <= n_wbl;
                    r_wbw   <= n_wbw;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line  <= req_addr[ADDR_BITS-1:2];
            r_word  <= req_addr[1:0];
            r_store <= i_req.is_store;
            r_m     <= MW'(req_addr[ADDR_BITS-1:2]) & sib_mask;
        end
        if (r_state == S_QUO) begin
            r_q <= quo_prod[47:32];
        end
        if (r_state == S_REM) begin
            r_set <= rem_fix[SET_W-1:0];
        end
        if (r_state == S_UPD) begin
            r_rsp.hit                  <= hit;
            r_rsp.dirty_evicted        <= evict;
            r_rsp.evicted_dirty_words  <= ev_words;
            r_rsp.fill_total           <= n_fills;
            r_rsp.writeback_line_total <= n_wbl;
            r_rsp.writeback_word_total <= n_wbw;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_valid_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_UPD))
        else $error("response without update step");

    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("response strobe longer than one cycle");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.hit) |-> (!o_rsp.dirty_evicted && o_rsp.evicted_dirty_words == '0))
        else $error("hit reported an eviction");

    a_evict_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.dirty_evicted == (o_rsp.evicted_dirty_words != '0)))
        else $error("eviction flag and word count disagree");

    a_miss_counts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.hit) |-> (o_rsp.fill_total != '0))
        else $error("miss without a fill count");

endmodule

`default_nettype wire

>>> sv/lcmwc_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module lcmwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> sim/lru_cache_miss_writeback_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_cache_miss_writeback_counter: directed and random
// cache accesses over several geometries, checked against a scoreboard that tracks
// the cache contents and totals. Depends on lcmwc_pkg and the block's RTL.

class cache_outcome_board;
    lcmwc_pkg::t_rsp pending_outcomes[$];
    bit [28:0] tag_mem [8192];
    bit        valid_mem [8192];
    bit [3:0]  dirty_mem [8192];
    bit [1:0]  order_mem [2048][4];
    bit [47:0] fills;
    bit [47:0] lines_back;
    bit [47:0] words_back;
    bit [3:0]  sets_log2;
    bit [2:0]  ways_cfg;
    int        mismatches;
    int        checked;
    int        hits;
    int        dirty_evicts;

    function new();
        int s, p;
        for (s = 0; s < 2048; s++)
            for (p = 0; p < 4; p++)
                order_mem[s][p] = p[1:0];
        sets_log2    = lcmwc_pkg::SIB_RESET;
        ways_cfg     = lcmwc_pkg::WAYS_RESET;
        fills        = '0;
        lines_back   = '0;
        words_back   = '0;
        mismatches   = 0;
        checked      = 0;
        hits         = 0;
        dirty_evicts = 0;
    endfunction

    function bit [47:0] sat_add(bit [47:0] a, bit [2:0] b);
        bit [48:0] s;
        s = {1'b0, a} + 49'(b);
        return (s > {1'b0, lcmwc_pkg::COUNT_MAX}) ? lcmwc_pkg::COUNT_MAX : s[47:0];
    endfunction

    function void apply_reg(logic [lcmwc_pkg::CFG_IDX_W-1:0] idx,
                            logic [lcmwc_pkg::CFG_DATA_W-1:0] val);
        if (idx == lcmwc_pkg::REG_SET_INDEX_BITS)
            sets_log2 = val;
        else if (idx == lcmwc_pkg::REG_WAYS_IN_USE)
            ways_cfg = val[2:0];
    endfunction

    function lcmwc_pkg::t_rsp predict_access(lcmwc_pkg::t_req r);
        lcmwc_pkg::t_rsp o;
        bit [28:0] line;
        bit [31:0] mask;
        bit        found;
        bit [1:0]  moved;
        int        nways, set_idx, pos, hpos, slot, k;
        o     = '0;
        line  = r.dword_addr[30:2];
        mask  = (32'd1 << sets_log2) - 32'd1;
        set_idx = ({3'b0, line} & mask) % 2048;
        if (ways_cfg == 0)
            nways = 1;
        else if (ways_cfg > 4)
            nways = 4;
        else
            nways = ways_cfg;
        found = 1'b0;
        hpos  = 0;
        for (pos = 0; pos < nways; pos++) begin
            if (!found) begin
                slot = set_idx * 4 + order_mem[set_idx][pos];
                if (valid_mem[slot] && tag_mem[slot] == line) begin
                    found = 1'b1;
                    hpos  = pos;
                end
            end
        end
        if (!found) begin
            hpos = nways - 1;
            slot = set_idx * 4 + order_mem[set_idx][hpos];
            if (valid_mem[slot] && dirty_mem[slot] != 4'd0) begin
                o.dirty_evicted       = 1'b1;
                o.evicted_dirty_words = dirty_mem[slot][0] + dirty_mem[slot][1]
                                      + dirty_mem[slot][2] + dirty_mem[slot][3];
                lines_back = sat_add(lines_back, 3'd1);
                words_back = sat_add(words_back, o.evicted_dirty_words);
            end
            fills           = sat_add(fills, 3'd1);
            tag_mem[slot]   = line;
            valid_mem[slot] = 1'b1;
            dirty_mem[slot] = 4'd0;
        end
        slot = set_idx * 4 + order_mem[set_idx][hpos];
        if (r.is_store)
            dirty_mem[slot][r.dword_addr[1:0]] = 1'b1;
        moved = order_mem[set_idx][hpos];
        for (k = hpos; k > 0; k--)
            order_mem[set_idx][k] = order_mem[set_idx][k-1];
        order_mem[set_idx][0] = moved;
        o.hit                  = found;
        o.fill_total           = fills;
        o.writeback_line_total = lines_back;
        o.writeback_word_total = words_back;
        return o;
    endfunction

    function void note_access(lcmwc_pkg::t_req r);
        pending_outcomes.push_back(predict_access(r));
    endfunction

    task flag_mismatch(string what, logic [47:0] got, logic [47:0] want);
        mismatches++;
        $display("MISMATCH after %0d results, %s: got %0h expected %0h",
                 checked, what, got, want);
    endtask

    task check_outcome(lcmwc_pkg::t_rsp got);
        lcmwc_pkg::t_rsp want;
        if (pending_outcomes.size() == 0) begin
            flag_mismatch("result with no request waiting", '0, '0);
            return;
        end
        want = pending_outcomes.pop_front();
        checked++;
        if (want.hit)
            hits++;
        if (want.dirty_evicted)
            dirty_evicts++;
        if (got.hit !== want.hit)
            flag_mismatch("hit", got.hit, want.hit);
        if (got.dirty_evicted !== want.dirty_evicted)
            flag_mismatch("dirty_evicted", got.dirty_evicted, want.dirty_evicted);
        if (got.evicted_dirty_words !== want.evicted_dirty_words)
            flag_mismatch("evicted_dirty_words", got.evicted_dirty_words,
                          want.evicted_dirty_words);
        if (got.fill_total !== want.fill_total)
            flag_mismatch("fill_total", got.fill_total, want.fill_total);
        if (got.writeback_line_total !== want.writeback_line_total)
            flag_mismatch("writeback_line_total", got.writeback_line_total,
                          want.writeback_line_total);
        if (got.writeback_word_total !== want.writeback_word_total)
            flag_mismatch("writeback_word_total", got.writeback_word_total,
                          want.writeback_word_total);
    endtask
endclass

module lru_cache_miss_writeback_counter_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 8;
    localparam int POOL_N         = 16;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    lcmwc_pkg::t_req                  i_req;
    logic                             busy;
    logic                             o_valid;
    lcmwc_pkg::t_rsp                  o_rsp;
    logic                             i_cfg_we;
    logic [lcmwc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [lcmwc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cache_outcome_board board;
    int                 idle_pct;
    int                 quiet_cycles;
    int                 n_geom;
    bit [28:0]          line_pool [POOL_N];
    logic [3:0]         phase_sets [NUM_PHASES];
    logic [3:0]         phase_ways [NUM_PHASES];
    int                 phase_idle [NUM_PHASES];

    lru_cache_miss_writeback_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                board.check_outcome(o_rsp);
            if (start && !busy)
                board.note_access(i_req);
        end
        if (i_rst_n && ((start && !busy) || o_valid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
        $display("lru_cache_miss_writeback_counter verification failed");
        $finish;
    end

    function automatic lcmwc_pkg::t_req make_req(bit [30:0] a, bit st);
        lcmwc_pkg::t_req r;
        r.dword_addr = a;
        r.is_store   = st;
        return r;
    endfunction

    // mostly reuse and same-set conflicts so hits and dirty evictions are common
    function automatic lcmwc_pkg::t_req next_access();
        lcmwc_pkg::t_req r;
        int              pick, k;
        bit [28:0]       ln;
        bit [31:0]       rnd;
        pick = $urandom_range(99);
        k    = $urandom_range(POOL_N - 1);
        rnd  = $urandom;
        if (pick < 50) begin
            ln = line_pool[k];
        end else if (pick < 75) begin
            ln        = line_pool[k];
            ln[28:11] = rnd[17:0];
            line_pool[k] = ln;
        end else if (pick < 90) begin
            ln = 29'($urandom_range(1023));
            line_pool[k] = ln;
        end else begin
            ln = rnd[28:0];
            line_pool[k] = ln;
        end
        r.dword_addr = {ln, 2'(rnd[31:30])};
        r.is_store   = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic send_access(input lcmwc_pkg::t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            i_req <= $urandom;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // hold off until every outstanding request has returned and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (board.pending_outcomes.size() != 0 || busy !== 1'b0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [3:0] sets_val, input logic [3:0] ways_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= lcmwc_pkg::REG_SET_INDEX_BITS;
        i_cfg_data <= sets_val;
        @(posedge i_clk);
        board.apply_reg(lcmwc_pkg::REG_SET_INDEX_BITS, sets_val);
        i_cfg_idx  <= lcmwc_pkg::REG_WAYS_IN_USE;
        i_cfg_data <= ways_val;
        @(posedge i_clk);
        board.apply_reg(lcmwc_pkg::REG_WAYS_IN_USE, ways_val);
        i_cfg_we   <= 1'b0;
        n_geom++;
    endtask

    initial begin
        int ph, n, i;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        idle_pct     = 0;
        quiet_cycles = 0;
        n_geom       = 0;
        board        = new();
        phase_sets   = '{4'd9, 4'd0, 4'd11, 4'd15, 4'd2, 4'd4, 4'd1, 4'd10};
        phase_ways   = '{4'd1, 4'd4, 4'd4, 4'd2, 4'd3, 4'd13, 4'd0, 4'd7};
        phase_idle   = '{0, 67, 10, 0, 67, 10, 0, 67};
        for (i = 0; i < POOL_N; i++)
            line_pool[i] = 29'($urandom_range(4095));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // reset geometry: 512 sets, direct mapped
        send_access(make_req(31'd0, 1'b0));
        send_access(make_req(31'd0, 1'b1));
        send_access(make_req(31'd1, 1'b1));
        send_access(make_req(31'd3, 1'b1));
        send_access(make_req(31'h7FFF_FFFF, 1'b1));
        send_access(make_req(31'h7FFF_FFFC, 1'b0));
        send_access(make_req(31'd2048, 1'b0));
        send_access(make_req(31'd0, 1'b0));

        // one set, four ways
        settle();
        set_geometry(4'd0, 4'd4);
        send_access(make_req(31'd16, 1'b1));
        send_access(make_req(31'd32, 1'b1));
        send_access(make_req(31'd48, 1'b1));
        send_access(make_req(31'd64, 1'b1));
        send_access(make_req(31'd16, 1'b0));
        send_access(make_req(31'd80, 1'b1));
        send_access(make_req(31'd0, 1'b0));

        // index wider than the set array, ways above max
        settle();
        set_geometry(4'd15, 4'd7);
        send_access(make_req(31'h7FFF_FFFF, 1'b0));
        send_access(make_req(31'h0000_2000, 1'b1));
        send_access(make_req(31'h0000_6000, 1'b0));

        // zero ways acts as one
        settle();
        set_geometry(4'd11, 4'd0);
        send_access(make_req(31'h0000_1234, 1'b1));
        send_access(make_req(31'h0000_3234, 1'b0));
        send_access(make_req(31'h0000_1234, 1'b0));

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            idle_pct = phase_idle[ph];
            set_geometry(phase_sets[ph], phase_ways[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) == 0)
                    settle();
                send_access(next_access());
            end
        end

        settle();
        repeat (12) @(posedge i_clk);

        $display("run: %0d accesses over %0d geometries, %0d hits, %0d dirty evictions",
                 board.checked, n_geom, board.hits, board.dirty_evicts);
        $display("totals: %0d fills, %0d lines and %0d words written back",
                 board.fills, board.lines_back, board.words_back);
        if (board.mismatches == 0 && board.pending_outcomes.size() == 0)
            $display("lru_cache_miss_writeback_counter verification clean");
        else
            $display("lru_cache_miss_writeback_counter verification failed");
        $finish;
    end
endmodule
